/* design/fwsc_pkg.sv */
// ----------------------------------------------------------------------------
// fwsc_pkg: shared types and constants of the fuzzy wall-follow speed core
// Set codes, item classification codes, register indexes and rule tables.
// ----------------------------------------------------------------------------
package fwsc_pkg;

   // speed level layout of the speed_levels register
   localparam int SPEED_W    = 16;
   localparam int NUM_LEVELS = 3;
   localparam int LEVEL_W    = SPEED_W * NUM_LEVELS;

   // rule grid: three sets per sensor
   localparam int NUM_SETS  = 3;
   localparam int NUM_RULES = NUM_SETS * NUM_SETS;

   // configuration port
   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FIRST_PLATEAU_END  = 3'd0,
      CSR_FIRST_CENTRE       = 3'd1,
      CSR_FIRST_FAR_START    = 3'd2,
      CSR_SECOND_PLATEAU_END = 3'd3,
      CSR_SECOND_CENTRE      = 3'd4,
      CSR_SECOND_FAR_START   = 3'd5,
      CSR_SPEED_LEVELS       = 3'd6
   } csr_index_type;

   // fuzzy sets, also used as speed level selects (slow, medium, fast)
   typedef enum logic [1:0] {
      SET_NEAR = 2'd0,
      SET_MED  = 2'd1,
      SET_FAR  = 2'd2
   } set_type;

   // how a range grades: one full set, or a ramp between a set and the next
   typedef enum logic [0:0] {
      KIND_FULL = 1'b0,
      KIND_RAMP = 1'b1
   } kind_type;

   // control bits of one sensor classification (kind plus set)
   localparam int CLS_CTRL_W = 3;

   // rule r pairs first sensor set r/3 with second sensor set r%3
   localparam set_type RULE_LEFT [NUM_RULES] = '{
      SET_MED, SET_NEAR, SET_NEAR, SET_FAR, SET_MED,
      SET_MED, SET_NEAR, SET_MED, SET_FAR
   };
   localparam set_type RULE_RIGHT [NUM_RULES] = '{
      SET_FAR, SET_MED, SET_FAR, SET_NEAR, SET_MED,
      SET_FAR, SET_FAR, SET_NEAR, SET_MED
   };

endpackage

/* design/fwsc_stream_if.sv */
// ----------------------------------------------------------------------------
// fwsc_stream_if: valid/ready channels of the fuzzy wall-follow speed core
// Range pair request channel and wheel speed response channel.
// ----------------------------------------------------------------------------
interface fwsc_req_if #(
   parameter int RANGE_BITS = 13
);
   logic                  valid;
   logic                  ready;
   logic [RANGE_BITS-1:0] first_range;
   logic [RANGE_BITS-1:0] second_range;

   modport source (output valid, first_range, second_range, input ready);
   modport sink   (input valid, first_range, second_range, output ready);
endinterface

interface fwsc_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] left_speed;
   logic [15:0] right_speed;

   modport source (output valid, left_speed, right_speed, input ready);
   modport sink   (input valid, left_speed, right_speed, output ready);
endinterface

/* design/fwsc_div.sv */
// ----------------------------------------------------------------------------
// fwsc_div: pipelined restoring divider
// One quotient bit per stage; the numerator's bits above QUO_W must already
// be below the denominator. One division per cycle while en is high.
// ----------------------------------------------------------------------------
module fwsc_div #(
   parameter int NUM_W = 29,
   parameter int DEN_W = 13,
   parameter int QUO_W = 16
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QUO_W-1:0] quo
);

   logic [DEN_W-1:0] rem_ff [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];
   logic [QUO_W-1:0] low_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];

   for (genvar s = 0; s < QUO_W; s++) begin : g_stage
      logic [DEN_W-1:0] rem_src;
      logic [DEN_W-1:0] den_src;
      logic [QUO_W-1:0] low_src;
      logic [QUO_W-1:0] quo_src;
      logic [DEN_W:0]   trial;
      logic [DEN_W:0]   diff;
      logic             take;

      if (s == 0) begin : g_first
         assign rem_src = DEN_W'(num[NUM_W-1:QUO_W]);
         assign den_src = den;
         assign low_src = num[QUO_W-1:0];
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[s-1];
         assign den_src = den_ff[s-1];
         assign low_src = low_ff[s-1];
         assign quo_src = quo_ff[s-1];
      end

      // shift in the next numerator bit and try a subtract
      assign trial = {rem_src, low_src[QUO_W-1]};
      assign diff  = trial - {1'b0, den_src};
      assign take  = (trial >= {1'b0, den_src});

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            den_ff[s] <= den_src;
            low_ff[s] <= {low_src[QUO_W-2:0], 1'b0};
            quo_ff[s] <= {quo_src[QUO_W-2:0], take};
         end
      end
   end

   assign quo = quo_ff[QUO_W-1];

endmodule

/* design/fwsc_front.sv */
// ----------------------------------------------------------------------------
// fwsc_front: range classification
// Grades each range against its three points: full set or ramp, and the
// ramp numerators and span that the back end divides.
// ----------------------------------------------------------------------------
module fwsc_front #(
   parameter int RANGE_BITS = 13
) (
   fwsc_req_if.sink              req,
   input  logic [RANGE_BITS-1:0] first_pts  [3],
   input  logic [RANGE_BITS-1:0] second_pts [3],
   output logic                  push_valid,
   input  logic                  push_ready,
   output logic [2*(3*RANGE_BITS+fwsc_pkg::CLS_CTRL_W)-1:0] push_data
);
   import fwsc_pkg::*;

   typedef struct packed {
      kind_type              kind;
      set_type               set;
      logic [RANGE_BITS-1:0] dn;
      logic [RANGE_BITS-1:0] up;
      logic [RANGE_BITS-1:0] span;
   } cls_type;

   typedef struct packed {
      cls_type s1;
      cls_type s2;
   } entry_type;

   entry_type entry;

   // grade x against plateau end p, centre c and far start f
   function automatic cls_type classify(input logic [RANGE_BITS-1:0] x,
                                        input logic [RANGE_BITS-1:0] p,
                                        input logic [RANGE_BITS-1:0] c,
                                        input logic [RANGE_BITS-1:0] f);
      cls_type r;
      r = '{kind: KIND_FULL, set: SET_FAR, dn: '0, up: '0, span: '0};
      if (x <= p && !(x == p && p == c)) begin
         r.set = SET_NEAR;
      end else if (x > p && x < c) begin
         r.kind = KIND_RAMP;
         r.set  = SET_NEAR;
         r.dn   = c - x;
         r.up   = x - p;
         r.span = c - p;
      end else if (x == c && c != f) begin
         r.set = SET_MED;
      end else if (x > c && x < f) begin
         r.kind = KIND_RAMP;
         r.set  = SET_MED;
         r.dn   = f - x;
         r.up   = x - c;
         r.span = f - c;
      end
      return r;
   endfunction

   // classify both sensors and hand the beat to the queue
   always_comb begin
      entry.s1 = classify(req.first_range, first_pts[0], first_pts[1], first_pts[2]);
      entry.s2 = classify(req.second_range, second_pts[0], second_pts[1], second_pts[2]);
   end

   assign push_valid = req.valid;
   assign push_data  = entry;
   assign req.ready  = push_ready;

endmodule

/* design/fwsc_queue.sv */
// ----------------------------------------------------------------------------
// fwsc_queue: two-entry queue between front and back
// Lets the front keep accepting while the back end stalls, until both entries are full.
// ----------------------------------------------------------------------------
module fwsc_queue #(
   parameter int WIDTH = 84
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] entries_ff [2];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // advance pointers and count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed beat
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("queue count above depth");
`endif

endmodule

/* design/fwsc_back.sv */
// ----------------------------------------------------------------------------
// fwsc_back: grading, rule weighting and defuzzification pipeline
// Ramp dividers, rule minimum, per-level weight sums, products and the final
// weighted-average dividers, all advancing together under one stall.
// ----------------------------------------------------------------------------
module fwsc_back #(
   parameter int RANGE_BITS    = 13,
   parameter int FRACTION_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic pop_valid,
   output logic pop_ready,
   input  logic [2*(3*RANGE_BITS+fwsc_pkg::CLS_CTRL_W)-1:0] pop_data,
   input  logic [fwsc_pkg::LEVEL_W-1:0] speed_levels,
   fwsc_rsp_if.source rsp
);
   import fwsc_pkg::*;

   localparam int GW    = FRACTION_BITS + 1;
   localparam int TOT_W = FRACTION_BITS + 4;
   localparam int SUM_W = TOT_W + SPEED_W;
   localparam logic [GW-1:0] GRADE_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

   typedef struct packed {
      kind_type              kind;
      set_type               set;
      logic [RANGE_BITS-1:0] dn;
      logic [RANGE_BITS-1:0] up;
      logic [RANGE_BITS-1:0] span;
   } cls_type;

   typedef struct packed {
      cls_type s1;
      cls_type s2;
   } entry_type;

   typedef struct packed {
      kind_type k1;
      set_type  t1;
      kind_type k2;
      set_type  t2;
   } meta_type;

   entry_type              entry;
   logic                   adv;
   logic [RANGE_BITS+FRACTION_BITS-1:0] ramp_num [4];
   logic [RANGE_BITS-1:0]  ramp_den [4];
   logic [FRACTION_BITS-1:0] ramp_quo [4];

   logic                   gvld_ff [FRACTION_BITS];
   meta_type               meta_ff [FRACTION_BITS];

   logic [GW-1:0]          g1 [NUM_SETS];
   logic [GW-1:0]          g2 [NUM_SETS];
   logic [GW-1:0]          w_in [NUM_RULES];
   logic [GW-1:0]          w_ff [NUM_RULES];
   logic                   vld_w_ff;

   logic [TOT_W-1:0]       lsum_in [NUM_LEVELS];
   logic [TOT_W-1:0]       rsum_in [NUM_LEVELS];
   logic [TOT_W-1:0]       tot_s_in;
   logic [TOT_W-1:0]       lsum_ff [NUM_LEVELS];
   logic [TOT_W-1:0]       rsum_ff [NUM_LEVELS];
   logic [TOT_W-1:0]       tot_s_ff;
   logic                   vld_s_ff;

   logic [SPEED_W-1:0]     level [NUM_LEVELS];
   logic [SUM_W-1:0]       lprod_in [NUM_LEVELS];
   logic [SUM_W-1:0]       rprod_in [NUM_LEVELS];
   logic [SUM_W-1:0]       lprod_ff [NUM_LEVELS];
   logic [SUM_W-1:0]       rprod_ff [NUM_LEVELS];
   logic [TOT_W-1:0]       tot_p_ff;
   logic                   vld_p_ff;

   logic [SUM_W-1:0]       lnum_ff;
   logic [SUM_W-1:0]       rnum_ff;
   logic [TOT_W-1:0]       tot_e_ff;
   logic                   vld_e_ff;

   logic                   fvld_ff  [SPEED_W];
   logic                   fzero_ff [SPEED_W];
   logic [SPEED_W-1:0]     left_quo;
   logic [SPEED_W-1:0]     right_quo;

   logic                   rsp_valid_ff;
   logic [SPEED_W-1:0]     left_ff;
   logic [SPEED_W-1:0]     right_ff;

   // the whole pipeline moves when the output register can take a beat
   assign adv       = !rsp_valid_ff || rsp.ready;
   assign pop_ready = adv;
   assign entry     = pop_data;

   // ramp grades: down and up fractions for each sensor
   always_comb begin
      ramp_num[0] = {entry.s1.dn, {FRACTION_BITS{1'b0}}};
      ramp_num[1] = {entry.s1.up, {FRACTION_BITS{1'b0}}};
      ramp_num[2] = {entry.s2.dn, {FRACTION_BITS{1'b0}}};
      ramp_num[3] = {entry.s2.up, {FRACTION_BITS{1'b0}}};
      ramp_den[0] = entry.s1.span;
      ramp_den[1] = entry.s1.span;
      ramp_den[2] = entry.s2.span;
      ramp_den[3] = entry.s2.span;
   end

   for (genvar d = 0; d < 4; d++) begin : g_ramp
      fwsc_div #(
         .NUM_W(RANGE_BITS + FRACTION_BITS),
         .DEN_W(RANGE_BITS),
         .QUO_W(FRACTION_BITS)
      ) u_div (
         .clock(clock),
         .en   (adv),
         .num  (ramp_num[d]),
         .den  (ramp_den[d]),
         .quo  (ramp_quo[d])
      );
   end

   // carry valid and set codes alongside the ramp dividers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FRACTION_BITS; i++) begin
            gvld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         gvld_ff[0] <= pop_valid;
         for (int i = 1; i < FRACTION_BITS; i++) begin
            gvld_ff[i] <= gvld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         meta_ff[0] <= '{k1: entry.s1.kind, t1: entry.s1.set,
                         k2: entry.s2.kind, t2: entry.s2.set};
         for (int i = 1; i < FRACTION_BITS; i++) begin
            meta_ff[i] <= meta_ff[i-1];
         end
      end
   end

   // build the three grades of each sensor and take the rule minimums
   always_comb begin
      for (int k = 0; k < NUM_SETS; k++) begin
         g1[k] = '0;
         g2[k] = '0;
      end
      if (meta_ff[FRACTION_BITS-1].k1 == KIND_FULL) begin
         g1[meta_ff[FRACTION_BITS-1].t1] = GRADE_ONE;
      end else if (meta_ff[FRACTION_BITS-1].t1 == SET_NEAR) begin
         g1[SET_NEAR] = GW'(ramp_quo[0]);
         g1[SET_MED]  = GW'(ramp_quo[1]);
      end else begin
         g1[SET_MED]  = GW'(ramp_quo[0]);
         g1[SET_FAR]  = GW'(ramp_quo[1]);
      end
      if (meta_ff[FRACTION_BITS-1].k2 == KIND_FULL) begin
         g2[meta_ff[FRACTION_BITS-1].t2] = GRADE_ONE;
      end else if (meta_ff[FRACTION_BITS-1].t2 == SET_NEAR) begin
         g2[SET_NEAR] = GW'(ramp_quo[2]);
         g2[SET_MED]  = GW'(ramp_quo[3]);
      end else begin
         g2[SET_MED]  = GW'(ramp_quo[2]);
         g2[SET_FAR]  = GW'(ramp_quo[3]);
      end
      for (int r = 0; r < NUM_RULES; r++) begin
         w_in[r] = (g1[r / NUM_SETS] < g2[r % NUM_SETS]) ?
                   g1[r / NUM_SETS] : g2[r % NUM_SETS];
      end
   end

   // sum the weights per speed level and in total
   always_comb begin
      tot_s_in = '0;
      for (int k = 0; k < NUM_LEVELS; k++) begin
         lsum_in[k] = '0;
         rsum_in[k] = '0;
      end
      for (int r = 0; r < NUM_RULES; r++) begin
         tot_s_in = tot_s_in + TOT_W'(w_ff[r]);
         for (int k = 0; k < NUM_LEVELS; k++) begin
            if (RULE_LEFT[r] == set_type'(k)) begin
               lsum_in[k] = lsum_in[k] + TOT_W'(w_ff[r]);
            end
            if (RULE_RIGHT[r] == set_type'(k)) begin
               rsum_in[k] = rsum_in[k] + TOT_W'(w_ff[r]);
            end
         end
      end
   end

   // scale each level sum by its speed
   always_comb begin
      for (int k = 0; k < NUM_LEVELS; k++) begin
         level[k]    = speed_levels[k*SPEED_W +: SPEED_W];
         lprod_in[k] = lsum_ff[k] * level[k];
         rprod_in[k] = rsum_ff[k] * level[k];
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_w_ff <= 1'b0;
         vld_s_ff <= 1'b0;
         vld_p_ff <= 1'b0;
         vld_e_ff <= 1'b0;
         for (int i = 0; i < SPEED_W; i++) begin
            fvld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vld_w_ff   <= gvld_ff[FRACTION_BITS-1];
         vld_s_ff   <= vld_w_ff;
         vld_p_ff   <= vld_s_ff;
         vld_e_ff   <= vld_p_ff;
         fvld_ff[0] <= vld_e_ff;
         for (int i = 1; i < SPEED_W; i++) begin
            fvld_ff[i] <= fvld_ff[i-1];
         end
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (adv) begin
         w_ff     <= w_in;
         lsum_ff  <= lsum_in;
         rsum_ff  <= rsum_in;
         tot_s_ff <= tot_s_in;
         lprod_ff <= lprod_in;
         rprod_ff <= rprod_in;
         tot_p_ff <= tot_s_ff;
         lnum_ff  <= lprod_ff[0] + lprod_ff[1] + lprod_ff[2];
         rnum_ff  <= rprod_ff[0] + rprod_ff[1] + rprod_ff[2];
         tot_e_ff <= tot_p_ff;
         fzero_ff[0] <= (tot_e_ff == '0);
         for (int i = 1; i < SPEED_W; i++) begin
            fzero_ff[i] <= fzero_ff[i-1];
         end
      end
   end

   // weighted average per wheel
   fwsc_div #(
      .NUM_W(SUM_W),
      .DEN_W(TOT_W),
      .QUO_W(SPEED_W)
   ) u_left_div (
      .clock(clock),
      .en   (adv),
      .num  (lnum_ff),
      .den  (tot_e_ff),
      .quo  (left_quo)
   );

   fwsc_div #(
      .NUM_W(SUM_W),
      .DEN_W(TOT_W),
      .QUO_W(SPEED_W)
   ) u_right_div (
      .clock(clock),
      .en   (adv),
      .num  (rnum_ff),
      .den  (tot_e_ff),
      .quo  (right_quo)
   );

   // output register; drop the quotient when no rule fired
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= fvld_ff[SPEED_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         left_ff  <= fzero_ff[SPEED_W-1] ? '0 : left_quo;
         right_ff <= fzero_ff[SPEED_W-1] ? '0 : right_quo;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.left_speed  = left_ff;
   assign rsp.right_speed = right_ff;

`ifndef SYNTHESIS
   a_total_nonzero: assert property (@(posedge clock) disable iff (reset)
      vld_s_ff |-> (tot_s_ff != '0))
      else $error("item reached weight sums with zero total weight");
`endif

`ifndef SYNTHESIS
   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(vld_w_ff) && $stable(vld_e_ff) && $stable(gvld_ff[0])))
      else $error("pipeline moved during a stall");
`endif

endmodule

/* design/fuzzy_wall_follow_speed_core.sv */
// ----------------------------------------------------------------------------
// fuzzy_wall_follow_speed_core: fuzzy wall-follow wheel speed controller
// Two side ranges in, left and right wheel speeds out, one result per pair.
// ----------------------------------------------------------------------------
// The core takes one range pair per cycle unless back-pressure holds it, and
// returns one speed pair per input, in order. After a pair enters the back
// end it passes through the pipelined membership ramp dividers, registers
// for rule weighting, level sums, products and numerators, the pipelined
// weighted-average dividers and the output register; a two-entry queue
// sits in front of the back end. A stalled response freezes the back end;
// the queue keeps the request side open for up to two more beats. Write
// configuration only while the core is idle.
module fuzzy_wall_follow_speed_core #(
   parameter int RANGE_BITS    = 13,
   parameter int FRACTION_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   fwsc_req_if.sink   req_port,
   fwsc_rsp_if.source rsp_port,
   input  logic                             csr_wr_en,
   input  logic [fwsc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fwsc_pkg::LEVEL_W-1:0]     csr_data
);
   import fwsc_pkg::*;

   localparam int ENTRY_W = 2 * (3 * RANGE_BITS + CLS_CTRL_W);

   logic [RANGE_BITS-1:0] first_pts_ff  [3];
   logic [RANGE_BITS-1:0] second_pts_ff [3];
   logic [LEVEL_W-1:0]    levels_ff;
   logic                  push_valid;
   logic                  push_ready;
   logic [ENTRY_W-1:0]    push_data;
   logic                  pop_valid;
   logic                  pop_ready;
   logic [ENTRY_W-1:0]    pop_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_pts_ff[0]  <= RANGE_BITS'(200);
         first_pts_ff[1]  <= RANGE_BITS'(500);
         first_pts_ff[2]  <= RANGE_BITS'(800);
         second_pts_ff[0] <= RANGE_BITS'(200);
         second_pts_ff[1] <= RANGE_BITS'(500);
         second_pts_ff[2] <= RANGE_BITS'(800);
         levels_ff        <= 48'h012C_0096_0032;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FIRST_PLATEAU_END:  first_pts_ff[0]  <= csr_data[RANGE_BITS-1:0];
            CSR_FIRST_CENTRE:       first_pts_ff[1]  <= csr_data[RANGE_BITS-1:0];
            CSR_FIRST_FAR_START:    first_pts_ff[2]  <= csr_data[RANGE_BITS-1:0];
            CSR_SECOND_PLATEAU_END: second_pts_ff[0] <= csr_data[RANGE_BITS-1:0];
            CSR_SECOND_CENTRE:      second_pts_ff[1] <= csr_data[RANGE_BITS-1:0];
            CSR_SECOND_FAR_START:   second_pts_ff[2] <= csr_data[RANGE_BITS-1:0];
            CSR_SPEED_LEVELS:       levels_ff        <= csr_data;
            default: begin
            end
         endcase
      end
   end

   fwsc_front #(
      .RANGE_BITS(RANGE_BITS)
   ) u_front (
      .req       (req_port),
      .first_pts (first_pts_ff),
      .second_pts(second_pts_ff),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data (push_data)
   );

   fwsc_queue #(
      .WIDTH(ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data (push_data),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data)
   );

   fwsc_back #(
      .RANGE_BITS   (RANGE_BITS),
      .FRACTION_BITS(FRACTION_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_data    (pop_data),
      .speed_levels(levels_ff),
      .rsp         (rsp_port)
   );

endmodule

/* dv/tb_fuzzy_wall_follow_speed_core.sv */
// ----------------------------------------------------------------------------
// tb_fuzzy_wall_follow_speed_core: self-checking bench of the wall-follow core
// Drives range pairs under several grading and speed settings, predicts the
// wheel speeds per pair and checks each response beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_fuzzy_wall_follow_speed_core;
   import fwsc_pkg::*;

   localparam int RB      = 13;
   localparam int FB      = 16;
   localparam int LATENCY = FB + 24;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [RB-1:0] first_range;
      logic [RB-1:0] second_range;
   } range_pair_type;

   typedef struct packed {
      logic [15:0] left_speed;
      logic [15:0] right_speed;
   } speed_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [LEVEL_W-1:0]     csr_data  = '0;

   fwsc_req_if #(.RANGE_BITS(RB)) req_port ();
   fwsc_rsp_if                    rsp_port ();

   fuzzy_wall_follow_speed_core #(.RANGE_BITS(RB), .FRACTION_BITS(FB)) dut (
      .clock(clock), .reset(reset), .req_port(req_port.sink),
      .rsp_port(rsp_port.source), .csr_wr_en(csr_wr_en),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor copy of the grading points and speed levels
   logic [RB-1:0]      pt_p [2];
   logic [RB-1:0]      pt_c [2];
   logic [RB-1:0]      pt_f [2];
   logic [LEVEL_W-1:0] levels;

   range_pair_type pending_pairs [$];
   speed_pair_type expected_speeds [$];
   int  errors = 0;
   int  idle_cycles = 0;
   bit  quiet = 1'b0;
   bit  hold_send = 1'b0;
   int  req_gap = 0;
   int  rsp_gap = 0;

   function automatic logic [63:0] ramp_grade(logic [63:0] top, logic [63:0] span);
      return (top << FB) / span;
   endfunction

   // grade one range into near/medium/far memberships
   function automatic void grade_range(input logic [63:0] x, input int s,
                                       output logic [63:0] g [3]);
      logic [63:0] p, c, f;
      p = pt_p[s]; c = pt_c[s]; f = pt_f[s];
      g[0] = 0; g[1] = 0; g[2] = 0;
      if (x <= p && !(x == p && p == c)) g[0] = 64'd1 << FB;
      else if (x > p && x < c) begin
         g[0] = ramp_grade(c - x, c - p);
         g[1] = ramp_grade(x - p, c - p);
      end else if (x == c && c != f) g[1] = 64'd1 << FB;
      else if (x > c && x < f) begin
         g[1] = ramp_grade(f - x, f - c);
         g[2] = ramp_grade(x - c, f - c);
      end else if (x >= f) g[2] = 64'd1 << FB;
   endfunction

   function automatic speed_pair_type wheel_speeds(range_pair_type in);
      logic [63:0] g1 [3];
      logic [63:0] g2 [3];
      logic [63:0] w, total, lsum, rsum;
      speed_pair_type res;
      total = 0; lsum = 0; rsum = 0;
      grade_range(in.first_range, 0, g1);
      grade_range(in.second_range, 1, g2);
      for (int r = 0; r < NUM_RULES; r++) begin
         w = (g1[r/3] < g2[r%3]) ? g1[r/3] : g2[r%3];
         total += w;
         lsum += w * levels[16*RULE_LEFT[r] +: 16];
         rsum += w * levels[16*RULE_RIGHT[r] +: 16];
      end
      if (total == 0) res = '0;
      else begin
         res.left_speed  = 16'(lsum / total);
         res.right_speed = 16'(rsum / total);
      end
      return res;
   endfunction

   // driver: present queued pairs, with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_port.valid <= 1'b0;
      end else begin
         if (req_port.valid && req_port.ready) begin
            expected_speeds.push_back(wheel_speeds({req_port.first_range,
                                                    req_port.second_range}));
            void'(pending_pairs.pop_front());
         end
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_port.valid <= 1'b0;
         end else if (!quiet && !(req_port.valid && !req_port.ready)
                      && $urandom_range(0, 9) == 0) begin
            req_gap <= $urandom_range(0, 5);
            req_port.valid <= 1'b0;
         end else if (req_port.valid && !req_port.ready) begin
            req_port.valid <= 1'b1;
         end else if (!hold_send && pending_pairs.size() != 0) begin
            range_pair_type nx;
            nx = pending_pairs[0];
            req_port.valid        <= 1'b1;
            req_port.first_range  <= nx.first_range;
            req_port.second_range <= nx.second_range;
         end else begin
            req_port.valid <= 1'b0;
         end
      end
   end

   // monitor: random back-pressure, compare beats with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_port.ready <= 1'b0;
      end else begin
         if (rsp_port.valid && rsp_port.ready) begin
            if (expected_speeds.size() == 0) begin
               $display("%0t: unexpected beat left=%0d right=%0d", $time,
                        rsp_port.left_speed, rsp_port.right_speed);
               errors++;
            end else begin
               speed_pair_type e;
               e = expected_speeds.pop_front();
               if (e.left_speed !== rsp_port.left_speed) begin
                  $display("%0t: left_speed expected %0d actual %0d", $time,
                           e.left_speed, rsp_port.left_speed);
                  errors++;
               end
               if (e.right_speed !== rsp_port.right_speed) begin
                  $display("%0t: right_speed expected %0d actual %0d", $time,
                           e.right_speed, rsp_port.right_speed);
                  errors++;
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_port.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_gap <= $urandom_range(0, 5);
            rsp_port.ready <= 1'b0;
         end else begin
            rsp_port.ready <= 1'b1;
         end
      end
   end

   // watchdog: count cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_port.valid && req_port.ready) || (rsp_port.valid && rsp_port.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic write_reg(csr_index_type idx, logic [LEVEL_W-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      case (idx)
         CSR_FIRST_PLATEAU_END:  pt_p[0] = val[RB-1:0];
         CSR_FIRST_CENTRE:       pt_c[0] = val[RB-1:0];
         CSR_FIRST_FAR_START:    pt_f[0] = val[RB-1:0];
         CSR_SECOND_PLATEAU_END: pt_p[1] = val[RB-1:0];
         CSR_SECOND_CENTRE:      pt_c[1] = val[RB-1:0];
         CSR_SECOND_FAR_START:   pt_f[1] = val[RB-1:0];
         CSR_SPEED_LEVELS:       levels  = val;
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // wait for the core to drain before touching configuration
   task automatic drain();
      while (pending_pairs.size() != 0 || req_port.valid || expected_speeds.size() != 0)
         @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic set_points(int s, int p, int c, int f);
      write_reg(csr_index_type'(3*s),     LEVEL_W'(p));
      write_reg(csr_index_type'(3*s + 1), LEVEL_W'(c));
      write_reg(csr_index_type'(3*s + 2), LEVEL_W'(f));
   endtask

   // pick a grading point or a range up to 1100 most of the time
   function automatic logic [RB-1:0] pick_range(int s);
      int k;
      k = $urandom_range(0, 9);
      case (k)
         0: return RB'($urandom);
         1: return pt_p[s];
         2: return pt_c[s];
         3: return pt_f[s];
         4: return RB'($urandom_range(0, 5000));
         default: return RB'($urandom_range(0, 1100));
      endcase
   endfunction

   task automatic queue_random(int n);
      for (int i = 0; i < n; i++)
         pending_pairs.push_back({pick_range(0), pick_range(1)});
   endtask

   initial begin
      req_port.valid = 1'b0;
      req_port.first_range = '0;
      req_port.second_range = '0;
      rsp_port.ready = 1'b0;
      pt_p = '{13'd200, 13'd200};
      pt_c = '{13'd500, 13'd500};
      pt_f = '{13'd800, 13'd800};
      levels = 48'd1288500019250;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes and each grading region at reset settings
      pending_pairs.push_back({13'd0, 13'd0});
      pending_pairs.push_back({13'h1fff, 13'h1fff});
      pending_pairs.push_back({13'd0, 13'h1fff});
      pending_pairs.push_back({13'd5000, 13'd0});
      pending_pairs.push_back({13'd200, 13'd500});
      pending_pairs.push_back({13'd350, 13'd650});
      pending_pairs.push_back({13'd800, 13'd201});
      pending_pairs.push_back({13'd799, 13'd499});
      pending_pairs.push_back({13'h0aaa, 13'h1555});
      drain();

      // hold the sender while ten random pairs are queued, then release it
      hold_send = 1'b1;
      queue_random(10);
      repeat (5) @(posedge clock);
      hold_send = 1'b0;
      drain();

      // zero-width ramps, below the lowest point, and points out of order
      set_points(0, 300, 300, 300);
      set_points(1, 100, 100, 600);
      write_reg(CSR_SPEED_LEVELS, 48'hffff_ffff_ffff);
      pending_pairs.push_back({13'd300, 13'd100});
      pending_pairs.push_back({13'd299, 13'd50});
      pending_pairs.push_back({13'd301, 13'd350});
      pending_pairs.push_back({13'd0, 13'd600});
      drain();
      set_points(0, 900, 400, 100);
      set_points(1, 0, 0, 0);
      write_reg(CSR_SPEED_LEVELS, 48'h0);
      pending_pairs.push_back({13'd0, 13'd0});
      pending_pairs.push_back({13'd500, 13'd1});
      drain();
      set_points(0, 8191, 8191, 8191);
      set_points(1, 5000, 5000, 5000);
      write_reg(CSR_SPEED_LEVELS, 48'h1234_8000_7fff);
      pending_pairs.push_back({13'h1fff, 13'd5000});
      pending_pairs.push_back({13'd4999, 13'd5001});
      queue_random(6);
      drain();

      // random phases over random settings, mostly in order
      for (int ph = 0; ph < 8; ph++) begin
         for (int s = 0; s < 2; s++) begin
            int p, c, f;
            p = $urandom_range(0, 1500);
            c = p + $urandom_range(0, 1500);
            f = c + $urandom_range(0, 1500);
            if ($urandom_range(0, 7) == 0) set_points(s, $urandom, $urandom, $urandom);
            else set_points(s, p, c, f);
         end
         write_reg(CSR_SPEED_LEVELS, LEVEL_W'({$urandom, $urandom}));
         if (ph == 7) quiet = 1'b1;
         queue_random(120);
         drain();
      end

      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
